>>> src/plid_pkg.sv
// Shared types and constants for the positional list block.
// Holds the operation and status codes and the controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps

package plid_pkg;

  localparam int COUNT_BITS    = 7;
  localparam int FUNC_BITS     = 2;
  localparam int STATUS_BITS   = 2;
  localparam int DEPTH_DEF     = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam logic [COUNT_BITS-1:0] CAP_RESET = 7'd64;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_INSERT = 2'd0,
    FN_SET    = 2'd1,
    FN_GET    = 2'd2,
    FN_DELETE = 2'd3
  } func_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // latch the request
    logic eval;      // register status, clear data, read the addressed slot
    logic cap_rd;    // capture the read word as result data
    logic wr_val;    // write the request value at the addressed slot
    logic up;        // one step of the insert shift
    logic down;      // one step of the delete shift
    logic fill_inc;
    logic fill_dec;
    logic load_out;  // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  err;       // request is rejected (valid during evaluation)
    func_t func;
    logic  up_more;   // insert shift has entries left to move
    logic  down_more; // delete shift has entries left to move
  } sts_t;

endpackage

>>> src/positional_list_insert_delete_top.sv
// Top level of the positional list block: controller, datapath, config port.
// Depends on plid_pkg, plid_ctrl, plid_dp (and plid_ram through the datapath).
//
// Usage:
//   Requests enter on in_valid/in_ready with in_func (insert, set, get,
//   delete), a 1-based in_position and in_value. Each request returns one
//   result on out_valid/out_ready: out_status, out_data (word read, word
//   replaced or word removed, zero otherwise) and out_count (entries after).
//   The capacity register is written on cfg_valid/cfg_ready (ready whenever
//   out of reset); write it only while no request is in flight.
// Timing: one request at a time, set by the entry RAM (one read and one write
//   port, registered read). After acceptance a request is evaluated; a
//   rejected one goes straight to its result, get or set reads the slot
//   (set also writes it), insert moves entries up then writes the value, and
//   delete reads the slot then moves entries down (one entry moved per cycle).
//   The result turns valid in the cycle the next request can be taken.
// Reset: empties the list and sets capacity to 64; no clearing pass.
// Stall: a finished result waits in the output register; the next request
//   is accepted meanwhile and its result holds until the register frees.
`timescale 1ns / 1ps

module positional_list_insert_delete_top #(
  parameter int DEPTH     = plid_pkg::DEPTH_DEF,
  parameter int WORD_BITS = plid_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [plid_pkg::FUNC_BITS-1:0]       in_func,
  input  logic [plid_pkg::COUNT_BITS-1:0]      in_position,
  input  logic signed [WORD_BITS-1:0]          in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [plid_pkg::STATUS_BITS-1:0]     out_status,
  output logic signed [WORD_BITS-1:0]          out_data,
  output logic [plid_pkg::COUNT_BITS-1:0]      out_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [plid_pkg::COUNT_BITS-1:0]      cfg_data
);

  plid_pkg::cmd_t cmd;
  plid_pkg::sts_t sts;

  // Capacity is a plain register: take every write at once, except in reset
  assign cfg_ready = rst_n;

  plid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plid_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_func),
    .in_position (in_position),
    .in_value    (in_value),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .out_status  (out_status),
    .out_data    (out_data),
    .out_count   (out_count)
  );

endmodule

>>> src/plid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the list entry storage. No dependencies.
`timescale 1ns / 1ps

module plid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/plid_ctrl.sv
// Sequencing state machine for the positional list block.
// Depends on plid_pkg for the command and status structs.
`timescale 1ns / 1ps

module plid_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  plid_pkg::sts_t  sts,
  output plid_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RDW,
    S_UP,
    S_INS,
    S_DOWN,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.err) state_nxt = S_DONE;
        else if (sts.func == plid_pkg::FN_INSERT) state_nxt = S_UP;
        else state_nxt = S_RDW;
      end
      S_RDW: begin
        cmd.cap_rd = 1'b1;
        cmd.wr_val = (sts.func == plid_pkg::FN_SET);
        if (sts.func == plid_pkg::FN_DELETE) state_nxt = S_DOWN;
        else state_nxt = S_DONE;
      end
      S_UP: begin
        cmd.up = 1'b1;
        if (!sts.up_more) state_nxt = S_INS;
      end
      S_INS: begin
        cmd.wr_val   = 1'b1;
        cmd.fill_inc = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DOWN: begin
        cmd.down     = 1'b1;
        cmd.fill_dec = !sts.down_more;
        if (!sts.down_more) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = !out_valid_r || out_ready;
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("accepted request did not move to evaluation");

  a_reject_skips_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && sts.err) |=> (state_r == S_DONE))
    else $error("rejected request touched the list");

endmodule

>>> src/plid_dp.sv
// Datapath for the positional list block: request, status, fill and capacity
// registers, the shift cursor and the entry RAM. Depends on plid_pkg, plid_ram.
`timescale 1ns / 1ps

module plid_dp #(
  parameter int DEPTH     = plid_pkg::DEPTH_DEF,
  parameter int WORD_BITS = plid_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  plid_pkg::cmd_t                       cmd,
  output plid_pkg::sts_t                       sts,
  input  logic [plid_pkg::FUNC_BITS-1:0]       in_func,
  input  logic [plid_pkg::COUNT_BITS-1:0]      in_position,
  input  logic signed [WORD_BITS-1:0]          in_value,
  input  logic                                 cfg_we,
  input  logic [plid_pkg::COUNT_BITS-1:0]      cfg_data,
  output logic [plid_pkg::STATUS_BITS-1:0]     out_status,
  output logic signed [WORD_BITS-1:0]          out_data,
  output logic [plid_pkg::COUNT_BITS-1:0]      out_count
);

  localparam int CW = plid_pkg::COUNT_BITS;
  localparam int AW = $clog2(DEPTH);

  logic [CW-1:0]          fill_r, cap_r, eff_cap;
  logic [CW-1:0]          pos_r, cur_r, wdst_r, slot;
  logic [WORD_BITS-1:0]   val_r, data_r, rdata;
  plid_pkg::func_t        func_r;
  plid_pkg::status_t      status_r, status_c;
  logic                   pend_r, pend_nxt;
  logic [CW:0]            fill_p1;
  logic                   up_more, down_more;
  logic                   re, we;
  logic [AW-1:0]          raddr, waddr;
  logic [WORD_BITS-1:0]   wdata;
  logic [plid_pkg::STATUS_BITS-1:0] out_status_r;
  logic [WORD_BITS-1:0]   out_data_r;
  logic [CW-1:0]          out_count_r;

  // Capacity above the storage depth saturates at the depth
  assign eff_cap = (32'(cap_r) > DEPTH) ? CW'(DEPTH) : cap_r;
  assign slot    = pos_r - 1'b1;
  assign fill_p1 = {1'b0, fill_r} + 1'b1;

  always_comb begin
    status_c = plid_pkg::ST_OK;
    if (func_r == plid_pkg::FN_INSERT) begin
      if (eff_cap == '0 || fill_r >= eff_cap) status_c = plid_pkg::ST_FULL;
      else if (pos_r == '0 || {1'b0, pos_r} > fill_p1) status_c = plid_pkg::ST_BADPOS;
    end else begin
      if (eff_cap == '0 || fill_r == '0) status_c = plid_pkg::ST_EMPTY;
      else if (pos_r == '0 || pos_r > fill_r) status_c = plid_pkg::ST_BADPOS;
    end
  end

  assign up_more   = (cur_r > slot);
  assign down_more = (cur_r < fill_r);

  assign sts.err       = (status_c != plid_pkg::ST_OK);
  assign sts.func      = func_r;
  assign sts.up_more   = up_more;
  assign sts.down_more = down_more;

  // RAM ports: slot read on evaluation, otherwise one shift read per step
  always_comb begin
    re    = 1'b0;
    raddr = AW'(slot);
    priority if (cmd.eval) begin
      re    = 1'b1;
      raddr = AW'(slot);
    end else if (cmd.up && up_more) begin
      re    = 1'b1;
      raddr = AW'(cur_r - 1'b1);
    end else if (cmd.down && down_more) begin
      re    = 1'b1;
      raddr = AW'(cur_r);
    end
  end

  assign we    = cmd.wr_val || (pend_r && (cmd.up || cmd.down));
  assign waddr = cmd.wr_val ? AW'(slot) : AW'(wdst_r);
  assign wdata = cmd.wr_val ? val_r : rdata;

  always_comb begin
    pend_nxt = 1'b0;
    if (cmd.up) pend_nxt = up_more;
    else if (cmd.down) pend_nxt = down_more;
  end

  plid_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      cap_r  <= plid_pkg::CAP_RESET;
      pend_r <= 1'b0;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (cmd.fill_inc) fill_r <= fill_r + 1'b1;
      else if (cmd.fill_dec) fill_r <= fill_r - 1'b1;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= plid_pkg::func_t'(in_func);
      pos_r  <= in_position;
      val_r  <= in_value;
      // Insert walks down from the top entry, the others walk up past the slot
      cur_r  <= (plid_pkg::func_t'(in_func) == plid_pkg::FN_INSERT) ? fill_r : in_position;
    end else if (cmd.up && up_more) begin
      cur_r  <= cur_r - 1'b1;
      wdst_r <= cur_r;
    end else if (cmd.down && down_more) begin
      cur_r  <= cur_r + 1'b1;
      wdst_r <= cur_r - 1'b1;
    end
    if (cmd.eval) begin
      status_r <= status_c;
      data_r   <= '0;
    end else if (cmd.cap_rd) begin
      data_r <= rdata;
    end
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_data_r   <= data_r;
      out_count_r  <= fill_r;
    end
  end

  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= DEPTH)
    else $error("fill exceeds storage depth");

  a_write_port_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_val |-> !pend_r)
    else $error("value write collides with a pending shift write");

  a_grow_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_inc |-> (status_r == plid_pkg::ST_OK && fill_r < eff_cap))
    else $error("fill grew on a rejected or full insert");

  a_shrink_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_dec |-> (fill_r != '0 && status_r == plid_pkg::ST_OK))
    else $error("fill shrank on an empty list or rejected delete");

endmodule
